[rtl/fne_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fne_pkg
// Command codes, sine coefficients and controller/datapath interface types
// for the Fourier number embedding block.
// ----------------------------------------------------------------------------
package fne_pkg;

  localparam logic [2:0] CMD_WR_FREQ = 3'd0;
  localparam logic [2:0] CMD_WR_WEIGHT = 3'd1;
  localparam logic [2:0] CMD_WR_BIAS = 3'd2;
  localparam logic [2:0] CMD_EMBED = 3'd3;
  localparam logic [2:0] CMD_READ = 3'd4;

  localparam int ITEM_W = 10;

  localparam logic [30:0] SIN_A1 = 31'd1686629713;
  localparam logic [30:0] SIN_A3 = 31'd693598669;
  localparam logic [30:0] SIN_A5 = 31'd85569306;
  localparam logic [30:0] SIN_A7 = 31'd5026995;
  localparam logic [30:0] SIN_A9 = 31'd172272;

  typedef struct packed {
    logic              emb_start;
    logic              freq_rd;
    logic              phase_mul;
    logic              sin_go;
    logic              sin_cos;
    logic              rd_start;
    logic              acc_init;
    logic              mac_issue;
    logic              finish;
    logic [ITEM_W-1:0] item;
  } fne_cmd_t;

  typedef struct packed {
    logic sin_done;
    logic mac_idle;
  } fne_stat_t;

  function automatic logic [30:0] sin_coef(input logic [2:0] step);
    logic [30:0] c;
    case (step)
      3'd1: c = SIN_A7;
      3'd2: c = SIN_A5;
      3'd3: c = SIN_A3;
      3'd4: c = SIN_A1;
      default: c = 31'd0;
    endcase
    return c;
  endfunction

endpackage

[rtl/fne_sine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fne_sine
// Iterative sine of a 32-bit phase over one shared multiplier, Q16.16 result.
// ----------------------------------------------------------------------------
module fne_sine
  import fne_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] phase,
  output logic        done,
  output logic [31:0] result
);

  logic        active;
  logic        mphase;
  logic [2:0]  step;
  logic [1:0]  quad;
  logic [30:0] z;
  logic [30:0] z2;
  logic [30:0] t;
  logic [61:0] prod;
  logic [30:0] mul_a;
  logic [30:0] mul_b;
  logic [30:0] prod_hi;
  logic [31:0] rnd;
  logic [17:0] mag;
  logic [31:0] mag_c;

  always_comb begin
    case (step)
      3'd0: begin
        mul_a = z;
        mul_b = z;
      end
      3'd1: begin
        mul_a = SIN_A9;
        mul_b = z2;
      end
      3'd5: begin
        mul_a = t;
        mul_b = z;
      end
      default: begin
        mul_a = t;
        mul_b = z2;
      end
    endcase
  end

  assign prod_hi = prod[60:30];
  assign rnd = {1'b0, prod_hi} + 32'd8192;
  assign mag = rnd[31:14];
  assign mag_c = (mag > 18'd65536) ? 32'd65536 : {14'd0, mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        step <= 3'd0;
        mphase <= 1'b0;
        quad <= phase[31:30];
        z <= phase[30] ? (31'h40000000 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
      end else if (active) begin
        if (!mphase) begin
          prod <= 62'(mul_a) * 62'(mul_b);
          mphase <= 1'b1;
        end else begin
          mphase <= 1'b0;
          step <= step + 3'd1;
          case (step)
            3'd0: z2 <= prod_hi;
            3'd5: begin
              result <= quad[1] ? (32'd0 - mag_c) : mag_c;
              done <= 1'b1;
              active <= 1'b0;
            end
            default: t <= sin_coef(step) - prod_hi;
          endcase
        end
      end
    end
  end

endmodule

[rtl/fne_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fne_datapath
// Stores, phase multiplier, sine unit and projection multiply-accumulate.
// ----------------------------------------------------------------------------
module fne_datapath
  import fne_pkg::*;
#(
  parameter int OUT_DIM = 768,
  parameter int HALF_DIM = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         command,
  input  logic [17:0]        index,
  input  logic signed [31:0] data_word,
  input  fne_cmd_t           cmd,
  output fne_stat_t          stat,
  output logic               strobe,
  output logic [9:0]         output_index,
  output logic signed [31:0] output_value
);

  localparam int FEAT_DIM = 2 * HALF_DIM + 1;
  localparam int ROW_WORDS = OUT_DIM * FEAT_DIM;
  localparam int FQA = (HALF_DIM > 1) ? $clog2(HALF_DIM) : 1;
  localparam int FA = $clog2(FEAT_DIM);
  localparam int BA = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
  localparam int WA = $clog2(ROW_WORDS);
  localparam int ACC_W = 58;

  logic [31:0] freq_mem [HALF_DIM];
  logic [31:0] weight_mem [ROW_WORDS];
  logic [31:0] bias_mem [OUT_DIM];
  logic [31:0] feat_mem [FEAT_DIM];

  logic [31:0]             x_reg;
  logic [31:0]             fq_q;
  logic [31:0]             phase_q;
  logic [FA-1:0]           feat_waddr;
  logic                    feat_valid;
  logic [31:0]             bias_q;
  logic [WA-1:0]           wbase;
  logic signed [31:0]      w_q;
  logic signed [31:0]      f_q;
  logic                    fv_q;
  logic signed [63:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic                    v1;
  logic                    v2;
  logic                    sin_done;
  logic [31:0]             sin_result;
  logic [31:0]             sin_phase;
  logic signed [31:0]      f_op;
  logic signed [63:0]      term;
  logic                    feat_we;
  logic [FA-1:0]           feat_wa;
  logic [31:0]             feat_wd;

  assign sin_phase = cmd.sin_cos ? (phase_q + 32'h40000000) : phase_q;

  fne_sine u_sine (
    .clk   (clk),
    .rst   (rst),
    .go    (cmd.sin_go),
    .phase (sin_phase),
    .done  (sin_done),
    .result(sin_result)
  );

  assign stat.sin_done = sin_done;
  assign stat.mac_idle = !v1 && !v2;

  always_ff @(posedge clk) begin
    if (wr_en && command == CMD_WR_FREQ && 32'(index) < 32'(HALF_DIM)) begin
      freq_mem[FQA'(index)] <= data_word;
    end
    if (cmd.freq_rd) begin
      fq_q <= freq_mem[FQA'(cmd.item)];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && command == CMD_WR_WEIGHT && 32'(index) < 32'(ROW_WORDS)) begin
      weight_mem[WA'(index)] <= data_word;
    end
    if (cmd.mac_issue) begin
      w_q <= weight_mem[wbase + WA'(cmd.item)];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && command == CMD_WR_BIAS && 32'(index) < 32'(OUT_DIM)) begin
      bias_mem[BA'(index)] <= data_word;
    end
    if (cmd.rd_start) begin
      bias_q <= bias_mem[BA'(index)];
    end
  end

  always_comb begin
    feat_we = cmd.emb_start || sin_done;
    feat_wa = cmd.emb_start ? FA'(0) : feat_waddr;
    feat_wd = cmd.emb_start ? data_word : sin_result;
  end

  always_ff @(posedge clk) begin
    if (feat_we) begin
      feat_mem[feat_wa] <= feat_wd;
    end
    if (cmd.mac_issue) begin
      f_q <= feat_mem[FA'(cmd.item)];
    end
  end

  assign f_op = fv_q ? f_q : 32'sd0;
  assign term = (prod + 64'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      feat_valid <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      strobe <= 1'b0;
    end else begin
      if (cmd.emb_start) begin
        feat_valid <= 1'b1;
        x_reg <= data_word;
      end
      if (cmd.phase_mul) begin
        phase_q <= x_reg * fq_q;
      end
      if (cmd.sin_go) begin
        feat_waddr <= cmd.sin_cos ? FA'(32'(cmd.item) + 1 + HALF_DIM) : FA'(32'(cmd.item) + 1);
      end
      if (cmd.rd_start) begin
        output_index <= index[9:0];
        wbase <= WA'(32'(index) * 32'(FEAT_DIM));
      end
      if (cmd.acc_init) begin
        acc <= ACC_W'($signed(bias_q));
      end else if (v2) begin
        acc <= acc + ACC_W'(term);
      end
      if (cmd.mac_issue) begin
        fv_q <= feat_valid;
      end
      v1 <= cmd.mac_issue;
      v2 <= v1;
      if (v1) begin
        prod <= w_q * f_op;
      end
      strobe <= cmd.finish;
      if (cmd.finish) begin
        if (acc > ACC_W'(64'sd2147483647)) begin
          output_value <= 32'sh7FFFFFFF;
        end else if (acc < ACC_W'(-64'sd2147483648)) begin
          output_value <= 32'sh80000000;
        end else begin
          output_value <= 32'(acc);
        end
      end
    end
  end

endmodule

[rtl/fne_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fne_ctrl
// Request decode and sequencing of the embed and projection passes.
// ----------------------------------------------------------------------------
module fne_ctrl
  import fne_pkg::*;
#(
  parameter int OUT_DIM = 768,
  parameter int HALF_DIM = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  command,
  input  logic [17:0] index,
  input  fne_stat_t   stat,
  output fne_cmd_t    cmd,
  output logic        wr_en,
  output logic        busy
);

  localparam int FEAT_DIM = 2 * HALF_DIM + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_E_RD, S_E_MUL, S_E_SIN, S_E_SINW, S_E_COS, S_E_COSW,
    S_R_LOAD, S_R_RUN, S_R_DRAIN
  } state_t;

  state_t            state;
  logic [ITEM_W-1:0] item;
  logic              accept;
  logic              rd_ok;

  assign busy = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);
  assign rd_ok = 32'(index) < 32'(OUT_DIM);
  assign wr_en = accept && (command inside {CMD_WR_FREQ, CMD_WR_WEIGHT, CMD_WR_BIAS});

  always_comb begin
    cmd.emb_start = accept && command == CMD_EMBED;
    cmd.rd_start = accept && command == CMD_READ && rd_ok;
    cmd.freq_rd = state == S_E_RD;
    cmd.phase_mul = state == S_E_MUL;
    cmd.sin_go = state == S_E_SIN || state == S_E_COS;
    cmd.sin_cos = state == S_E_COS;
    cmd.acc_init = state == S_R_LOAD;
    cmd.mac_issue = state == S_R_RUN;
    cmd.finish = state == S_R_DRAIN && stat.mac_idle;
    cmd.item = item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      item <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          item <= '0;
          if (cmd.emb_start) begin
            state <= S_E_RD;
          end else if (cmd.rd_start) begin
            state <= S_R_LOAD;
          end
        end
        S_E_RD: state <= S_E_MUL;
        S_E_MUL: state <= S_E_SIN;
        S_E_SIN: state <= S_E_SINW;
        S_E_SINW: if (stat.sin_done) begin
          state <= S_E_COS;
        end
        S_E_COS: state <= S_E_COSW;
        S_E_COSW: if (stat.sin_done) begin
          if (item == ITEM_W'(HALF_DIM - 1)) begin
            state <= S_IDLE;
          end else begin
            item <= item + ITEM_W'(1);
            state <= S_E_RD;
          end
        end
        S_R_LOAD: state <= S_R_RUN;
        S_R_RUN: begin
          if (item == ITEM_W'(FEAT_DIM - 1)) begin
            state <= S_R_DRAIN;
          end else begin
            item <= item + ITEM_W'(1);
          end
        end
        S_R_DRAIN: if (stat.mac_idle) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/fourier_number_embedding.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fourier_number_embedding
// Fourier feature embedding of a Q16.16 scalar with a linear projection.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low.
// Write requests load the frequency, weight and bias stores in that cycle
// and never raise busy. An embed request builds the 2*HALF_DIM+1 features;
// each frequency takes a read, a phase multiply and two iterative sines on
// one shared multiplier, and an embed keeps busy high throughout. A read
// request walks 2*HALF_DIM+1 multiply-accumulates through one pipelined
// multiplier and keeps busy high until its result appears on output_index
// and output_value, with strobe high for exactly one cycle. The receiver
// cannot stall, so the result must be taken in that cycle. Reads out of
// range and unknown codes do nothing. Reset clears the sequencer and makes
// all features read zero until the first embed; the stores hold no value
// until written.
// ----------------------------------------------------------------------------
module fourier_number_embedding
  import fne_pkg::*;
#(
  parameter int OUT_DIM = 768,
  parameter int HALF_DIM = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         command,
  input  logic [17:0]        index,
  input  logic signed [31:0] data_word,
  output logic               strobe,
  output logic [9:0]         output_index,
  output logic signed [31:0] output_value
);

  fne_cmd_t  cmd;
  fne_stat_t stat;
  logic      wr_en;

  fne_ctrl #(.OUT_DIM(OUT_DIM), .HALF_DIM(HALF_DIM)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .command(command),
    .index  (index),
    .stat   (stat),
    .cmd    (cmd),
    .wr_en  (wr_en),
    .busy   (busy)
  );

  fne_datapath #(.OUT_DIM(OUT_DIM), .HALF_DIM(HALF_DIM)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .command     (command),
    .index       (index),
    .data_word   (data_word),
    .cmd         (cmd),
    .stat        (stat),
    .strobe      (strobe),
    .output_index(output_index),
    .output_value(output_value)
  );

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy)) else $error("Result without a pending read.");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (32'(output_index) < 32'(OUT_DIM))) else $error("Result index out of range.");

  a_embed_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_EMBED) |=> busy) else $error("Embed did not start.");

endmodule

[tb/fourier_number_embedding_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fourier_number_embedding_tb
// Self-checking testbench for the Fourier number embedding block.
// ----------------------------------------------------------------------------
// The testbench loads the frequency, weight and bias stores, then sends embed
// and read requests. A predictor in the testbench keeps its own copy of every
// store and of the features. It computes each read result and queues it.
// Every strobed result is compared with the oldest queued one. The testbench
// reads only weight rows and biases that it has fully written. It sends
// directed extremes first, then random traffic with different idle rates.
// ----------------------------------------------------------------------------
module fourier_number_embedding_tb
  import fne_pkg::*;
();

  localparam int OUT_N = 768;
  localparam int HALF_N = 128;
  localparam int FEAT_N = 2 * HALF_N + 1;
  localparam int WEIGHT_N = OUT_N * FEAT_N;
  localparam int STALL_LIMIT = 50000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] command = CMD_WR_FREQ;
  logic [17:0] index = '0;
  logic signed [31:0] data_word = '0;
  logic strobe;
  logic [9:0] output_index;
  logic signed [31:0] output_value;

  logic [31:0] freq_mem [0:HALF_N-1];
  logic [31:0] weight_mem [0:WEIGHT_N-1];
  logic [31:0] bias_mem [0:OUT_N-1];
  logic [31:0] feature_mem [0:FEAT_N-1];

  typedef struct packed {
    logic [9:0]  row;
    logic [31:0] value;
  } projection_t;

  projection_t pending_projections[$];
  int loaded_rows[$];
  int error_count = 0;
  int reads_checked = 0;
  int embeds_sent = 0;
  int requests_sent = 0;
  int idle_pct = 0;
  int stall_cycles = 0;

  always #4 clk = ~clk;

  fourier_number_embedding u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .index(index), .data_word(data_word), .strobe(strobe),
    .output_index(output_index), .output_value(output_value)
  );

  function automatic logic [31:0] phase_sine(input logic [31:0] p);
    logic [63:0] z, z2, t, s;
    z = {34'd0, p[29:0]};
    if (p[30]) z = (64'd1 << 30) - z;
    z2 = (z * z) >> 30;
    t = SIN_A9;
    t = SIN_A7 - ((t * z2) >> 30);
    t = SIN_A5 - ((t * z2) >> 30);
    t = SIN_A3 - ((t * z2) >> 30);
    t = SIN_A1 - ((t * z2) >> 30);
    s = (t * z) >> 30;
    s = (s + 64'd8192) >> 14;
    if (s > 64'd65536) s = 64'd65536;
    return p[31] ? (32'd0 - s[31:0]) : s[31:0];
  endfunction

  function automatic logic [31:0] project_row(input int row);
    longint acc;
    longint prod;
    acc = longint'($signed(bias_mem[row]));
    for (int i = 0; i < FEAT_N; i++) begin
      prod = longint'($signed(weight_mem[row * FEAT_N + i])) *
             longint'($signed(feature_mem[i]));
      acc += (prod + 64'sd32768) >>> 16;
    end
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  task automatic apply_request(input logic [2:0] cmd, input logic [17:0] idx,
                               input logic [31:0] word);
    longint x;
    logic [63:0] prod;
    projection_t exp_item;
    case (cmd)
      CMD_WR_FREQ: if (idx < HALF_N) freq_mem[idx] = word;
      CMD_WR_WEIGHT: if (idx < WEIGHT_N) weight_mem[idx] = word;
      CMD_WR_BIAS: if (idx < OUT_N) bias_mem[idx] = word;
      CMD_EMBED: begin
        x = longint'($signed(word));
        feature_mem[0] = word;
        for (int i = 0; i < HALF_N; i++) begin
          prod = x * longint'($signed(freq_mem[i]));
          feature_mem[1 + i] = phase_sine(prod[31:0]);
          feature_mem[1 + HALF_N + i] = phase_sine(prod[31:0] + 32'h4000_0000);
        end
        embeds_sent++;
      end
      CMD_READ: if (idx < OUT_N) begin
        exp_item.row = idx[9:0];
        exp_item.value = project_row(idx);
        pending_projections = {pending_projections, exp_item};
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [2:0] cmd, input logic [17:0] idx,
                              input logic [31:0] word);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 20) gap++;
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    command = cmd;
    index = idx;
    data_word = word;
    do @(posedge clk); while (busy);
    apply_request(cmd, idx, word);
    requests_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_projections.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0001_0000;
      3: return 32'hFFFF_0000;
      4: return {{16{1'b0}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic load_row(input int row, input logic [31:0] bias_word, input int mode);
    logic [31:0] w;
    for (int i = 0; i < FEAT_N; i++) begin
      case (mode)
        0: w = 32'h7FFF_FFFF;
        1: w = 32'h8000_0000;
        default: w = pick_word();
      endcase
      send_request(CMD_WR_WEIGHT, 18'(row * FEAT_N + i), w);
    end
    send_request(CMD_WR_BIAS, 18'(row), bias_word);
    loaded_rows = {loaded_rows, row};
  endtask

  task automatic test_table_load();
    idle_pct = 0;
    for (int i = 0; i < HALF_N; i++) send_request(CMD_WR_FREQ, 18'(i), pick_word());
    load_row(0, 32'h7FFF_FFFF, 0);
    load_row(OUT_N - 1, 32'h8000_0000, 2);
  endtask

  task automatic test_read_before_embed();
    send_request(CMD_READ, 18'd0, 32'h0);
    send_request(CMD_READ, 18'(OUT_N - 1), 32'h0);
  endtask

  task automatic test_extremes();
    send_request(CMD_WR_FREQ, 18'd0, 32'h0001_0000);
    send_request(CMD_WR_FREQ, 18'd1, 32'h7FFF_FFFF);
    send_request(CMD_WR_FREQ, 18'd2, 32'h8000_0000);
    send_request(CMD_EMBED, 18'd0, 32'h7FFF_FFFF);
    send_request(CMD_READ, 18'd0, 32'h0);
    send_request(CMD_READ, 18'(OUT_N - 1), 32'h0);
    send_request(CMD_EMBED, 18'd0, 32'h8000_0000);
    send_request(CMD_READ, 18'd0, 32'h0);
    send_request(CMD_READ, 18'(OUT_N - 1), 32'h0);
    send_request(CMD_EMBED, 18'h3FFFF, 32'h0);
    send_request(CMD_READ, 18'(OUT_N - 1), 32'h0);
    send_request(CMD_EMBED, 18'd0, 32'h0000_4000);
    send_request(CMD_READ, 18'd0, 32'h0);
  endtask

  task automatic test_ignored_requests();
    send_request(CMD_WR_FREQ, 18'd128, 32'hDEAD_BEEF);
    send_request(CMD_WR_WEIGHT, 18'(WEIGHT_N), 32'hDEAD_BEEF);
    send_request(CMD_WR_WEIGHT, 18'h3FFFF, 32'hDEAD_BEEF);
    send_request(CMD_WR_BIAS, 18'd768, 32'hDEAD_BEEF);
    send_request(CMD_READ, 18'd768, 32'h0);
    send_request(CMD_READ, 18'h3FFFF, 32'h0);
    send_request(3'd5, 18'h3FFFF, 32'hFFFF_FFFF);
    send_request(3'd6, 18'h0, 32'h0);
    send_request(3'd7, 18'h2AAAA, 32'h5555_5555);
    send_request(CMD_READ, 18'd0, 32'h0);
  endtask

  task automatic test_random_traffic(input int count, input int pct);
    int r;
    int row;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      row = loaded_rows[$urandom_range(loaded_rows.size() - 1)];
      if (r < 25)
        send_request(CMD_WR_WEIGHT, 18'(row * FEAT_N + $urandom_range(FEAT_N - 1)),
                     pick_word());
      else if (r < 35)
        send_request(CMD_WR_WEIGHT, 18'($urandom), pick_word());
      else if (r < 45)
        send_request(CMD_WR_FREQ, 18'($urandom_range(255)), pick_word());
      else if (r < 52)
        send_request(CMD_WR_BIAS, 18'($urandom_range(1023)), pick_word());
      else if (r < 56)
        send_request(CMD_EMBED, 18'($urandom), pick_word());
      else if (r < 82)
        send_request(CMD_READ, 18'(row), $urandom);
      else if (r < 87)
        send_request(CMD_READ, 18'($urandom_range(OUT_N, 18'h3FFFF)), $urandom);
      else if (r < 92)
        send_request(3'($urandom_range(5, 7)), 18'($urandom), $urandom);
      else
        send_request(CMD_WR_BIAS, 18'(row), pick_word());
    end
  endtask

  always @(posedge clk) begin
    projection_t exp_item;
    if (!rst) begin
      if ((start && !busy) || strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (strobe) begin
        if (pending_projections.size() == 0) begin
          $display("%0t: unexpected result index %0d value %h", $time,
                   output_index, output_value);
          error_count++;
        end else begin
          exp_item = pending_projections.pop_front();
          if (output_index !== exp_item.row) begin
            $display("%0t: output_index expected %0d actual %0d", $time,
                     exp_item.row, output_index);
            error_count++;
          end
          if (output_value !== exp_item.value) begin
            $display("%0t: output_value row %0d expected %h actual %h", $time,
                     exp_item.row, exp_item.value, output_value);
            error_count++;
          end
          reads_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < FEAT_N; i++) feature_mem[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_table_load();
    test_read_before_embed();
    test_extremes();
    test_ignored_requests();
    wait_results_drained();
    test_random_traffic(70, 0);
    test_random_traffic(70, 63);
    wait_results_drained();
    test_random_traffic(70, 0);
    test_random_traffic(70, 36);
    wait_results_drained();
    repeat (300) @(posedge clk);
    $display("Sent %0d requests including %0d embeds; checked %0d projected results.",
             requests_sent, embeds_sent, reads_checked);
    $display("Idle rates of 0, 36 and 63 percent were used, with drains between phases.");
    if (error_count == 0 && pending_projections.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
